### sv/vlbt_pkg.sv
// Shared types, constants and triangle tables for the voxel boundary extractor.
// No dependencies; used by vlbt_emit and voxel_label_boundary_triangles.
package vlbt_pkg;

	localparam int MAX_AXIS_DEF   = 256;
	localparam int LABEL_BITS_DEF = 16;
	localparam int CFG_W          = 9;
	localparam int CFG_IDX_W      = 2;
	localparam int COORD_W        = 8;
	localparam int TRI_W          = 27;

	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_I = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_J = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_K = 2'd2;

	localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

	localparam logic [1:0] AX_K = 2'd0;
	localparam logic [1:0] AX_J = 2'd1;
	localparam logic [1:0] AX_I = 2'd2;

	typedef struct packed {
		logic       clr;
		logic [2:0] diff;
		logic [2:0] gt;
	} hand_ctl_t;

	typedef struct packed {
		logic [2:0] a;
		logic [2:0] b;
		logic [2:0] c;
	} tri_ids_t;

	// corner ids of one triangle: neighbor axis, cell label greater, triangle of pair
	function automatic tri_ids_t tri_corners(input logic [1:0] ax, input logic g,
			input logic t);
		tri_ids_t r;
		r = '{a: 3'd0, b: 3'd0, c: 3'd0};
		case ({ax, g, t})
			{AX_K, 1'b0, 1'b0}: r = '{a: 3'd1, b: 3'd4, c: 3'd2};
			{AX_K, 1'b0, 1'b1}: r = '{a: 3'd4, b: 3'd5, c: 3'd2};
			{AX_K, 1'b1, 1'b0}: r = '{a: 3'd2, b: 3'd5, c: 3'd4};
			{AX_K, 1'b1, 1'b1}: r = '{a: 3'd2, b: 3'd4, c: 3'd1};
			{AX_J, 1'b0, 1'b0}: r = '{a: 3'd0, b: 3'd3, c: 3'd1};
			{AX_J, 1'b0, 1'b1}: r = '{a: 3'd3, b: 3'd4, c: 3'd1};
			{AX_J, 1'b1, 1'b0}: r = '{a: 3'd0, b: 3'd1, c: 3'd3};
			{AX_J, 1'b1, 1'b1}: r = '{a: 3'd1, b: 3'd4, c: 3'd3};
			{AX_I, 1'b0, 1'b0}: r = '{a: 3'd3, b: 3'd5, c: 3'd4};
			{AX_I, 1'b0, 1'b1}: r = '{a: 3'd3, b: 3'd6, c: 3'd5};
			{AX_I, 1'b1, 1'b0}: r = '{a: 3'd6, b: 3'd3, c: 3'd5};
			{AX_I, 1'b1, 1'b1}: r = '{a: 3'd3, b: 3'd4, c: 3'd5};
			default: r = '{a: 3'd0, b: 3'd0, c: 3'd0};
		endcase
		return r;
	endfunction

	// corner offset as {slow, middle, fast}
	function automatic logic [2:0] corner_ofs(input logic [2:0] id);
		logic [2:0] r;
		case (id)
			3'd0: r = 3'b010;
			3'd1: r = 3'b011;
			3'd2: r = 3'b001;
			3'd3: r = 3'b110;
			3'd4: r = 3'b111;
			3'd5: r = 3'b101;
			3'd6: r = 3'b100;
			default: r = 3'b000;
		endcase
		return r;
	endfunction

endpackage

### sv/vlbt_emit.sv
// Triangle emitter: walks the differing neighbor axes of one cell, two triangles each,
// numbers them and holds each in the output register. Depends on vlbt_pkg.
module vlbt_emit #(
	parameter int MAX_AXIS = vlbt_pkg::MAX_AXIS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        h_valid,
	output logic                        h_ready,
	input  vlbt_pkg::hand_ctl_t         h_ctl,
	input  logic [$clog2(MAX_AXIS)-1:0] h_ci,
	input  logic [$clog2(MAX_AXIS)-1:0] h_cj,
	input  logic [$clog2(MAX_AXIS)-1:0] h_ck,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [vlbt_pkg::COORD_W-1:0] corner_a_x,
	output logic [vlbt_pkg::COORD_W-1:0] corner_a_y,
	output logic [vlbt_pkg::COORD_W-1:0] corner_a_z,
	output logic [vlbt_pkg::COORD_W-1:0] corner_b_x,
	output logic [vlbt_pkg::COORD_W-1:0] corner_b_y,
	output logic [vlbt_pkg::COORD_W-1:0] corner_b_z,
	output logic [vlbt_pkg::COORD_W-1:0] corner_c_x,
	output logic [vlbt_pkg::COORD_W-1:0] corner_c_y,
	output logic [vlbt_pkg::COORD_W-1:0] corner_c_z,
	output logic [vlbt_pkg::TRI_W-1:0]   triangle_index,
	output logic                        last_of_run
);
	import vlbt_pkg::*;

	localparam int PW = $clog2(MAX_AXIS);
	localparam int XW = (PW + 1 > COORD_W) ? PW + 1 : COORD_W;

	function automatic logic [COORD_W-1:0] coord(input logic [PW-1:0] base,
			input logic d);
		logic [XW-1:0] s;
		s = XW'(base) + XW'(d);
		return s[COORD_W-1:0];
	endfunction

	logic               s2_v_q;
	logic               half_s2;
	logic [2:0]         diff_s2;
	logic [2:0]         gt_s2;
	logic [PW-1:0]      ci_s2;
	logic [PW-1:0]      cj_s2;
	logic [PW-1:0]      ck_s2;
	logic [TRI_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic [COORD_W-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q, cx_q, cy_q, cz_q;
	logic [TRI_W-1:0]   idx_q;
	logic               last_q;

	logic       [1:0] ax;
	logic             g;
	tri_ids_t         ids;
	logic       [2:0] oa, ob, oc;
	logic             single;
	logic             last;
	logic             emit;
	logic             load;
	logic       [2:0] diff_clr;

	always_comb begin
		if (diff_s2[0]) begin
			ax = AX_K;
			g  = gt_s2[0];
		end else if (diff_s2[1]) begin
			ax = AX_J;
			g  = gt_s2[1];
		end else begin
			ax = AX_I;
			g  = gt_s2[2];
		end
	end

	assign ids      = tri_corners(ax, g, half_s2);
	assign oa       = corner_ofs(ids.a);
	assign ob       = corner_ofs(ids.b);
	assign oc       = corner_ofs(ids.c);
	assign diff_clr = diff_s2 & (diff_s2 - 3'd1);
	assign single   = (diff_clr == 3'd0);
	assign last     = half_s2 && single;
	assign emit     = s2_v_q && (!out_valid_q || out_ready);
	assign h_ready  = !s2_v_q || (emit && last);
	assign load     = h_valid && h_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q      <= 1'b0;
			half_s2     <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				s2_v_q  <= (h_ctl.diff != 3'd0);
				half_s2 <= 1'b0;
			end else if (emit && last) begin
				s2_v_q  <= 1'b0;
				half_s2 <= 1'b0;
			end else if (emit) begin
				half_s2 <= !half_s2;
			end
			if (load && h_ctl.clr) begin
				cnt_q <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + TRI_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			diff_s2 <= h_ctl.diff;
			gt_s2   <= h_ctl.gt;
			ci_s2   <= h_ci;
			cj_s2   <= h_cj;
			ck_s2   <= h_ck;
		end else if (emit && half_s2) begin
			diff_s2 <= diff_clr;
		end
		if (emit) begin
			ax_q   <= coord(ci_s2, oa[2]);
			ay_q   <= coord(cj_s2, oa[1]);
			az_q   <= coord(ck_s2, oa[0]);
			bx_q   <= coord(ci_s2, ob[2]);
			by_q   <= coord(cj_s2, ob[1]);
			bz_q   <= coord(ck_s2, ob[0]);
			cx_q   <= coord(ci_s2, oc[2]);
			cy_q   <= coord(cj_s2, oc[1]);
			cz_q   <= coord(ck_s2, oc[0]);
			idx_q  <= cnt_q;
			last_q <= last;
		end
	end

	assign out_valid      = out_valid_q;
	assign corner_a_x     = ax_q;
	assign corner_a_y     = ay_q;
	assign corner_a_z     = az_q;
	assign corner_b_x     = bx_q;
	assign corner_b_y     = by_q;
	assign corner_b_z     = bz_q;
	assign corner_c_x     = cx_q;
	assign corner_c_y     = cy_q;
	assign corner_c_z     = cz_q;
	assign triangle_index = idx_q;
	assign last_of_run    = last_q;

	a_busy_has_axis: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q |-> diff_s2 != 3'd0)
		else $error("emitter busy with no differing axis");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !last |=> s2_v_q)
		else $error("emitter dropped a cell before its last triangle");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !(load && h_ctl.clr) |=> cnt_q == $past(cnt_q) + TRI_W'(1))
		else $error("triangle count did not advance by one");

endmodule

### sv/voxel_label_boundary_triangles.sv
// An accepted voxel waits in stage 1 for its plane store reads, then passes to the emitter.
// Throughput: one triangle per cycle while out_ready holds; an interior voxel holds the plane store
// for three reads on its single read port plus handoff, a border voxel only for the handoff.
// Reset clears positions, counter, handshake state; sizes reset to 256.
// Plane store contents are undefined after reset and are never cleared.
// Depends on vlbt_pkg and vlbt_emit.
module voxel_label_boundary_triangles #(
	parameter int MAX_AXIS   = vlbt_pkg::MAX_AXIS_DEF,
	parameter int LABEL_BITS = vlbt_pkg::LABEL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [vlbt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vlbt_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [LABEL_BITS-1:0]         label,
	input  logic                          first_voxel,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vlbt_pkg::COORD_W-1:0]   corner_a_x,
	output logic [vlbt_pkg::COORD_W-1:0]   corner_a_y,
	output logic [vlbt_pkg::COORD_W-1:0]   corner_a_z,
	output logic [vlbt_pkg::COORD_W-1:0]   corner_b_x,
	output logic [vlbt_pkg::COORD_W-1:0]   corner_b_y,
	output logic [vlbt_pkg::COORD_W-1:0]   corner_b_z,
	output logic [vlbt_pkg::COORD_W-1:0]   corner_c_x,
	output logic [vlbt_pkg::COORD_W-1:0]   corner_c_y,
	output logic [vlbt_pkg::COORD_W-1:0]   corner_c_z,
	output logic [vlbt_pkg::TRI_W-1:0]     triangle_index,
	output logic                          last_of_run
);
	import vlbt_pkg::*;

	localparam int PW    = $clog2(MAX_AXIS);
	localparam int SW    = PW + 1;
	localparam int CW    = (SW > CFG_W) ? SW : CFG_W;
	localparam int AW    = 2 * PW;
	localparam int DEPTH = 1 << AW;

	localparam logic [1:0] PH_CUR  = 2'd0;
	localparam logic [1:0] PH_NBK  = 2'd1;
	localparam logic [1:0] PH_NBJ  = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	function automatic logic [SW-1:0] eff_size(input logic [CFG_W-1:0] r);
		logic [CW-1:0] rx;
		rx = CW'(r);
		if (rx == '0) begin
			return SW'(1);
		end else if (rx > CW'(MAX_AXIS)) begin
			return SW'(MAX_AXIS);
		end
		return SW'(rx);
	endfunction

	logic [CFG_W-1:0]      size_i_q, size_j_q, size_k_q;
	logic [PW-1:0]         pos_s_q, pos_m_q, pos_f_q;
	logic                  v_s1;
	logic [1:0]            phase_q;
	logic                  cell_s1;
	logic                  clr_s1;
	logic [LABEL_BITS-1:0] lab_s1;
	logic [PW-1:0]         ci_s1, cj_s1, ck_s1;
	logic [LABEL_BITS-1:0] cur_q, nbk_q, rd_data_q;
	logic [LABEL_BITS-1:0] mem [DEPTH];

	logic [SW-1:0] si, sj, sk;
	logic [PW-1:0] ps, pm, pf;
	logic [SW-1:0] ps1, pm1, pf1;
	logic          cell_in;
	logic [PW-1:0] ns, nm, nf;
	logic          accept;
	logic          h_valid, h_ready, s1_done;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [PW-1:0] ck_inc, cj_inc;
	hand_ctl_t     h_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_i_q <= SIZE_RESET;
			size_j_q <= SIZE_RESET;
			size_k_q <= SIZE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SIZE_I: size_i_q <= cfg_data;
				CFG_SIZE_J: size_j_q <= cfg_data;
				CFG_SIZE_K: size_k_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign si = eff_size(size_i_q);
	assign sj = eff_size(size_j_q);
	assign sk = eff_size(size_k_q);

	assign ps  = first_voxel ? '0 : pos_s_q;
	assign pm  = first_voxel ? '0 : pos_m_q;
	assign pf  = first_voxel ? '0 : pos_f_q;
	assign ps1 = SW'(ps) + SW'(1);
	assign pm1 = SW'(pm) + SW'(1);
	assign pf1 = SW'(pf) + SW'(1);

	assign cell_in = (ps != '0) && (pm1 < sj) && (pf1 < sk);

	always_comb begin
		ns = ps;
		nm = pm;
		nf = '0;
		if (pf1 >= sk) begin
			if (pm1 >= sj) begin
				nm = '0;
				ns = (ps1 >= si) ? '0 : ps1[PW-1:0];
			end else begin
				nm = pm1[PW-1:0];
			end
		end else begin
			nf = pf1[PW-1:0];
		end
	end

	assign h_valid  = v_s1 && (cell_s1 ? (phase_q == PH_DONE) : (phase_q == PH_CUR));
	assign s1_done  = h_valid && h_ready;
	assign in_ready = !v_s1 || s1_done;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_s_q <= '0;
			pos_m_q <= '0;
			pos_f_q <= '0;
			v_s1    <= 1'b0;
			phase_q <= PH_CUR;
		end else begin
			if (accept) begin
				pos_s_q <= ns;
				pos_m_q <= nm;
				pos_f_q <= nf;
			end
			if (accept) begin
				v_s1    <= 1'b1;
				phase_q <= PH_CUR;
			end else begin
				if (s1_done) begin
					v_s1 <= 1'b0;
				end
				if (v_s1 && cell_s1 && phase_q != PH_DONE) begin
					phase_q <= phase_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= cell_in;
			clr_s1  <= first_voxel;
			lab_s1  <= label;
			ci_s1   <= ps - PW'(1);
			cj_s1   <= pm;
			ck_s1   <= pf;
		end
	end

	assign ck_inc = ck_s1 + PW'(1);
	assign cj_inc = cj_s1 + PW'(1);

	assign rd_en   = v_s1 && cell_s1 && (phase_q != PH_DONE);
	assign wr_en   = v_s1 && (cell_s1 ? (phase_q == PH_NBJ) : (phase_q == PH_CUR));
	assign wr_addr = {cj_s1, ck_s1};

	always_comb begin
		case (phase_q)
			PH_CUR:  rd_addr = {cj_s1, ck_s1};
			PH_NBK:  rd_addr = {cj_s1, ck_inc};
			PH_NBJ:  rd_addr = {cj_inc, ck_s1};
			default: rd_addr = {cj_s1, ck_s1};
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= lab_s1;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (v_s1 && cell_s1 && phase_q == PH_NBK) begin
			cur_q <= rd_data_q;
		end
		if (v_s1 && cell_s1 && phase_q == PH_NBJ) begin
			nbk_q <= rd_data_q;
		end
	end

	always_comb begin
		h_ctl.clr = clr_s1;
		if (cell_s1) begin
			h_ctl.diff = {cur_q != lab_s1, cur_q != rd_data_q, cur_q != nbk_q};
			h_ctl.gt   = {cur_q > lab_s1, cur_q > rd_data_q, cur_q > nbk_q};
		end else begin
			h_ctl.diff = 3'd0;
			h_ctl.gt   = 3'd0;
		end
	end

	vlbt_emit #(
		.MAX_AXIS (MAX_AXIS)
	) u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.h_valid        (h_valid),
		.h_ready        (h_ready),
		.h_ctl          (h_ctl),
		.h_ci           (ci_s1),
		.h_cj           (cj_s1),
		.h_ck           (ck_s1),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.corner_a_x     (corner_a_x),
		.corner_a_y     (corner_a_y),
		.corner_a_z     (corner_a_z),
		.corner_b_x     (corner_b_x),
		.corner_b_y     (corner_b_y),
		.corner_b_z     (corner_b_z),
		.corner_c_x     (corner_c_x),
		.corner_c_y     (corner_c_y),
		.corner_c_z     (corner_c_z),
		.triangle_index (triangle_index),
		.last_of_run    (last_of_run)
	);

	a_border_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !cell_s1 |-> phase_q == PH_CUR)
		else $error("border item left the first phase");

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en |-> rd_addr != wr_addr)
		else $error("plane store read and write hit the same entry");

	a_handoff_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s1_done |=> !v_s1 || phase_q == PH_CUR)
		else $error("item after handoff did not start at the first phase");

endmodule

### dv/vlbt_face_checker.sv
// Boundary triangle checker: watches the size writes and both item channels,
// predicts the triangles of every voxel and compares them in order.
// Depends on vlbt_pkg for widths and register indexes.
module vlbt_face_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [vlbt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vlbt_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [vlbt_pkg::LABEL_BITS_DEF-1:0] label,
	input  logic                            first_voxel,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [vlbt_pkg::COORD_W-1:0]    corner_a_x,
	input  logic [vlbt_pkg::COORD_W-1:0]    corner_a_y,
	input  logic [vlbt_pkg::COORD_W-1:0]    corner_a_z,
	input  logic [vlbt_pkg::COORD_W-1:0]    corner_b_x,
	input  logic [vlbt_pkg::COORD_W-1:0]    corner_b_y,
	input  logic [vlbt_pkg::COORD_W-1:0]    corner_b_z,
	input  logic [vlbt_pkg::COORD_W-1:0]    corner_c_x,
	input  logic [vlbt_pkg::COORD_W-1:0]    corner_c_y,
	input  logic [vlbt_pkg::COORD_W-1:0]    corner_c_z,
	input  logic [vlbt_pkg::TRI_W-1:0]      triangle_index,
	input  logic                            last_of_run,
	output int                              pending,
	output int                              failures
);
	import vlbt_pkg::*;

	typedef struct packed {
		logic [23:0]      a;
		logic [23:0]      b;
		logic [23:0]      c;
		logic [TRI_W-1:0] index;
		logic             last;
	} face_tri_t;

	// corner ids per [axis k,j,i][cell label greater][triangle][corner]
	localparam logic [107:0] FACE_TAB = {
		3'd1, 3'd4, 3'd2,  3'd4, 3'd5, 3'd2,  3'd2, 3'd5, 3'd4,  3'd2, 3'd4, 3'd1,
		3'd0, 3'd3, 3'd1,  3'd3, 3'd4, 3'd1,  3'd0, 3'd1, 3'd3,  3'd1, 3'd4, 3'd3,
		3'd3, 3'd5, 3'd4,  3'd3, 3'd6, 3'd5,  3'd6, 3'd3, 3'd5,  3'd3, 3'd4, 3'd5
	};
	// corner offset as {slow, middle, fast}
	localparam logic [20:0] CORNER_OFS = {
		3'b010, 3'b011, 3'b001, 3'b110, 3'b111, 3'b101, 3'b100
	};

	logic [LABEL_BITS_DEF-1:0] plane_labels [0:65535];
	logic [CFG_W-1:0]   size_i, size_j, size_k;
	logic [COORD_W-1:0] at_slow, at_mid, at_fast;
	logic [TRI_W-1:0]   tri_count;
	face_tri_t          due_tris [$];
	int                 errors = 0;

	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] s);
		if (s == 0)
			return CFG_W'(1);
		if (s > MAX_AXIS_DEF)
			return CFG_W'(MAX_AXIS_DEF);
		return s;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report(what, got, want);
	endtask

	task automatic extract_faces(input logic [LABEL_BITS_DEF-1:0] lab, input logic first);
		logic [CFG_W-1:0]          si, sj, sk;
		logic [LABEL_BITS_DEF-1:0] cur;
		logic [LABEL_BITS_DEF-1:0] nb [3];
		logic [COORD_W-1:0]        ci, px, py, pz;
		logic [2:0]                id, ofs;
		logic [23:0]               pt [3];
		face_tri_t                 batch [6];
		int                        ax, tr, c, g, n;
		si = clamp_size(size_i);
		sj = clamp_size(size_j);
		sk = clamp_size(size_k);
		n = 0;
		if (first) begin
			at_slow = '0;
			at_mid = '0;
			at_fast = '0;
			tri_count = '0;
		end
		if (at_slow >= 1 && at_mid + 1 < sj && at_fast + 1 < sk) begin
			ci = at_slow - 8'd1;
			cur = plane_labels[{at_mid, at_fast}];
			nb[0] = plane_labels[{at_mid, at_fast + 8'd1}];
			nb[1] = plane_labels[{at_mid + 8'd1, at_fast}];
			nb[2] = lab;
			for (ax = 0; ax < 3; ax++) begin
				if (cur != nb[ax]) begin
					g = (cur > nb[ax]) ? 1 : 0;
					for (tr = 0; tr < 2; tr++) begin
						for (c = 0; c < 3; c++) begin
							id = FACE_TAB[(35 - (ax * 12 + g * 6 + tr * 3 + c)) * 3 +: 3];
							ofs = CORNER_OFS[(6 - id) * 3 +: 3];
							px = ci + ofs[2];
							py = at_mid + ofs[1];
							pz = at_fast + ofs[0];
							pt[c] = {px, py, pz};
						end
						batch[n] = '{a: pt[0], b: pt[1], c: pt[2], index: tri_count, last: 1'b0};
						tri_count = tri_count + 1'b1;
						n++;
					end
				end
			end
		end
		if (n > 0)
			batch[n-1].last = 1'b1;
		for (c = 0; c < n; c++)
			due_tris.insert(due_tris.size(), batch[c]);
		plane_labels[{at_mid, at_fast}] = lab;
		if (at_fast + 1 >= sk) begin
			at_fast = '0;
			if (at_mid + 1 >= sj) begin
				at_mid = '0;
				if (at_slow + 1 >= si)
					at_slow = '0;
				else
					at_slow++;
			end else begin
				at_mid++;
			end
		end else begin
			at_fast++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		face_tri_t want;
		if (!arst_n) begin
			size_i = SIZE_RESET;
			size_j = SIZE_RESET;
			size_k = SIZE_RESET;
			at_slow = '0;
			at_mid = '0;
			at_fast = '0;
			tri_count = '0;
			due_tris.delete();
			pending <= 0;
			failures <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_SIZE_I: size_i = cfg_data;
					CFG_SIZE_J: size_j = cfg_data;
					CFG_SIZE_K: size_k = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (due_tris.size() == 0) begin
					report("triangle with none due, index", 32'(triangle_index), 32'd0);
				end else begin
					want = due_tris.pop_front();
					check_field("corner_a_x", 32'(corner_a_x), 32'(want.a[23:16]));
					check_field("corner_a_y", 32'(corner_a_y), 32'(want.a[15:8]));
					check_field("corner_a_z", 32'(corner_a_z), 32'(want.a[7:0]));
					check_field("corner_b_x", 32'(corner_b_x), 32'(want.b[23:16]));
					check_field("corner_b_y", 32'(corner_b_y), 32'(want.b[15:8]));
					check_field("corner_b_z", 32'(corner_b_z), 32'(want.b[7:0]));
					check_field("corner_c_x", 32'(corner_c_x), 32'(want.c[23:16]));
					check_field("corner_c_y", 32'(corner_c_y), 32'(want.c[15:8]));
					check_field("corner_c_z", 32'(corner_c_z), 32'(want.c[7:0]));
					check_field("triangle_index", 32'(triangle_index), 32'(want.index));
					check_field("last_of_run", 32'(last_of_run), 32'(want.last));
				end
			end
			if (in_valid && in_ready)
				extract_faces(label, first_voxel);
			pending <= due_tris.size();
			failures <= errors;
		end
	end

endmodule

### dv/testbench.sv
// Top of the boundary triangle bench: clock, reset, size programming, voxel
// stimulus and output back-pressure. Needs vlbt_pkg, the block and vlbt_face_checker.
module testbench;
	import vlbt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int STALL_MAX      = 15;
	localparam int SETTLE         = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 60;
	localparam int OVERSIZE_ITEMS = 16;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_write;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]          cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [LABEL_BITS_DEF-1:0] label;
	logic                      first_voxel;
	logic                      out_valid;
	logic                      out_ready;
	logic [COORD_W-1:0]        corner_a_x, corner_a_y, corner_a_z;
	logic [COORD_W-1:0]        corner_b_x, corner_b_y, corner_b_z;
	logic [COORD_W-1:0]        corner_c_x, corner_c_y, corner_c_z;
	logic [TRI_W-1:0]          triangle_index;
	logic                      last_of_run;
	int                        pending;
	int                        failures;
	bit                        no_idle;
	int                        items_sent;
	int                        settings_used;
	int                        random_items;

	logic [LABEL_BITS_DEF-1:0] probe_labels [24] = '{
		16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h1234,
		16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h8001,
		16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF
	};

	voxel_label_boundary_triangles DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .label(label), .first_voxel(first_voxel),
		.out_valid(out_valid), .out_ready(out_ready),
		.corner_a_x(corner_a_x), .corner_a_y(corner_a_y), .corner_a_z(corner_a_z),
		.corner_b_x(corner_b_x), .corner_b_y(corner_b_y), .corner_b_z(corner_b_z),
		.corner_c_x(corner_c_x), .corner_c_y(corner_c_y), .corner_c_z(corner_c_z),
		.triangle_index(triangle_index), .last_of_run(last_of_run)
	);

	vlbt_face_checker face_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .label(label), .first_voxel(first_voxel),
		.out_valid(out_valid), .out_ready(out_ready),
		.corner_a_x(corner_a_x), .corner_a_y(corner_a_y), .corner_a_z(corner_a_z),
		.corner_b_x(corner_b_x), .corner_b_y(corner_b_y), .corner_b_z(corner_b_z),
		.corner_c_x(corner_c_x), .corner_c_y(corner_c_y), .corner_c_z(corner_c_z),
		.triangle_index(triangle_index), .last_of_run(last_of_run),
		.pending(pending), .failures(failures)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		int hold;
		out_ready <= 1'b0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				hold = no_idle ? 0 : $urandom_range(0, STALL_MAX);
				if (hold > 0)
					out_ready <= 1'b0;
			end else if (!out_ready) begin
				if (hold > 0)
					hold--;
				if (hold == 0)
					out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int idle_run;
		idle_run = 0;
		@(posedge arst_n);
		while (idle_run < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("FAIL voxel_label_boundary_triangles");
		$finish;
	end

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_sizes(input logic [CFG_W-1:0] si, input logic [CFG_W-1:0] sj,
			input logic [CFG_W-1:0] sk);
		settle();
		write_reg(CFG_SIZE_I, si);
		write_reg(CFG_SIZE_J, sj);
		write_reg(CFG_SIZE_K, sk);
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_SPARE, CFG_W'($urandom));
		cfg_write <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task automatic send_voxel(input logic [LABEL_BITS_DEF-1:0] lab, input logic first);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		label <= lab;
		first_voxel <= first;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_run(input int count, input bit restart);
		logic [LABEL_BITS_DEF-1:0] palette [4];
		logic [LABEL_BITS_DEF-1:0] lab;
		int k;
		for (k = 0; k < 4; k++)
			palette[k] = LABEL_BITS_DEF'($urandom);
		if ($urandom_range(0, 3) == 0)
			palette[0] = '0;
		if ($urandom_range(0, 3) == 0)
			palette[1] = '1;
		for (k = 0; k < count; k++) begin
			lab = ($urandom_range(0, 4) == 0) ? LABEL_BITS_DEF'($urandom) :
				palette[$urandom_range(0, 3)];
			send_voxel(lab, (k == 0 && restart) || ($urandom_range(0, 59) == 0));
		end
	endtask

	function automatic logic [CFG_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return CFG_W'(0);
		if (r == 1)
			return CFG_W'(1);
		return CFG_W'($urandom_range(2, 4));
	endfunction

	function automatic int clamp_dim(input logic [CFG_W-1:0] s);
		if (s == 0)
			return 1;
		if (s > MAX_AXIS_DEF)
			return MAX_AXIS_DEF;
		return int'(s);
	endfunction

	initial begin
		int k, n;
		logic [CFG_W-1:0] si, sj, sk;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		label <= '0;
		first_voxel <= 1'b0;
		no_idle <= 1'b1;
		items_sent = 0;
		settings_used = 0;
		random_items = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_sizes(CFG_W'(2), CFG_W'(2), CFG_W'(2));
		for (k = 0; k < 24; k++)
			send_voxel(probe_labels[k], k == 0);

		no_idle <= 1'b0;
		set_sizes(CFG_W'(4), CFG_W'(4), CFG_W'(4));
		send_run(43, 1'b1);
		set_sizes(CFG_W'(3), CFG_W'(2), CFG_W'(2));
		send_run(20, 1'b0);

		while (random_items < RANDOM_ITEMS) begin
			no_idle <= ($urandom_range(0, 3) == 0);
			si = pick_size();
			sj = pick_size();
			sk = pick_size();
			set_sizes(si, sj, sk);
			n = $urandom_range(1, 2) * (clamp_dim(si) * clamp_dim(sj) * clamp_dim(sk));
			if (n > 80)
				n = 80;
			send_run(n, 1'b1);
			random_items += n;
		end

		no_idle <= 1'b0;
		set_sizes(CFG_W'(2), CFG_W'(2), CFG_W'(300));
		send_run(OVERSIZE_ITEMS, 1'b1);
		set_sizes(CFG_W'(2), CFG_W'(511), CFG_W'(2));
		send_run(OVERSIZE_ITEMS, 1'b1);
		set_sizes(CFG_W'(256), CFG_W'(2), CFG_W'(2));
		send_run(OVERSIZE_ITEMS, 1'b1);

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d voxel items over %0d size settings", items_sent, settings_used);
		$display("incl. zero and oversize sizes, restarts, volume wrap and mid-volume shrink");
		if (failures == 0 && pending == 0)
			$display("PASS voxel_label_boundary_triangles");
		else
			$display("FAIL voxel_label_boundary_triangles");
		$finish;
	end

endmodule

### voxel_label_boundary_triangles.f
sv/vlbt_pkg.sv
sv/vlbt_emit.sv
sv/voxel_label_boundary_triangles.sv
dv/vlbt_face_checker.sv
dv/testbench.sv
